### rtl/mdcw_pkg.sv
// ----------------------------------------------------------------------------
// mdcw_pkg: shared constants and types for the motor drive command watchdog
// CAN identifiers, reset values, register indexes and the record passed from
// the command stage to the result stage.
// ----------------------------------------------------------------------------
package mdcw_pkg;

  localparam logic [10:0] ID_SPEED = 11'h300;
  localparam logic [10:0] ID_RELAY = 11'h310;
  localparam logic [10:0] ID_DIR   = 11'h320;
  localparam logic [10:0] ID_EMERG = 11'h210;
  localparam logic [10:0] FB_SPEED = 11'h301;
  localparam logic [10:0] FB_RELAY = 11'h311;
  localparam logic [10:0] FB_DIR   = 11'h321;

  localparam logic [6:0] SPEED_MAX = 7'd100;

  localparam int ELAPSED_W = 17;
  localparam int PROD_W    = 15;
  localparam int RECIP_W   = 13;
  localparam int SCALED_W  = PROD_W + RECIP_W;

  // floor(x / 100) == (x * 5243) >> 19 for every x below 2**15
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;

  localparam logic [15:0] WD_TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  FULL_SCALE_RST = 8'd255;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WD_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd1;

  typedef enum logic [1:0] {
    DUTY_KEEP,
    DUTY_ZERO,
    DUTY_CALC
  } duty_act_t;

  typedef struct packed {
    logic              fb_valid;
    logic [10:0]       fb_id;
    logic [6:0]        fb_value;
    logic              two;
    duty_act_t         duty_act;
    logic [PROD_W-1:0] prod;
    logic              relay_on;
    logic              reverse;
    logic              emergency;
    logic              offline;
  } mid_rec_t;

endpackage

### rtl/mdcw_cmd.sv
// ----------------------------------------------------------------------------
// mdcw_cmd: input register and command decode
// Holds the controller state, applies one frame or tick per transaction and
// registers the resulting record together with the speed-times-scale product.
// ----------------------------------------------------------------------------
module mdcw_cmd
  import mdcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [10:0] in_frame_id,
  input  logic        in_has_data,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] wd_timeout,
  input  logic [7:0]  full_scale,
  output logic        mid_valid,
  input  logic        mid_ready,
  output mid_rec_t    mid_rec
);

  logic        s1_v_r;
  logic        kind_r;
  logic [10:0] id_r;
  logic        has_r;
  logic [7:0]  data_r;

  logic [6:0]           target_r, target_nxt;
  logic                 relay_r, relay_nxt;
  logic                 fwd_r, fwd_nxt;
  logic                 emerg_r, emerg_nxt;
  logic                 off_r, off_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;

  logic     mid_v_r;
  mid_rec_t mid_r, mid_nxt;

  logic s1_adv;
  logic in_acc;
  logic is_cmd;
  logic zero_duty;
  logic dir_new;

  assign s1_adv   = s1_v_r && (!mid_v_r || mid_ready);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign is_cmd   = (id_r == ID_SPEED) || (id_r == ID_RELAY) || (id_r == ID_DIR) ||
                    (id_r == ID_EMERG);
  assign dir_new  = (data_r != 8'd0);

  always_comb begin
    target_nxt  = target_r;
    relay_nxt   = relay_r;
    fwd_nxt     = fwd_r;
    emerg_nxt   = emerg_r;
    off_nxt     = off_r;
    elapsed_nxt = elapsed_r;
    zero_duty   = 1'b0;
    mid_nxt     = '0;

    if (kind_r) begin
      if (elapsed_r != '1) begin
        elapsed_nxt = elapsed_r + 1'b1;
      end
    end else begin
      if (is_cmd) begin
        elapsed_nxt = '0;
        off_nxt     = 1'b0;
      end
      if (id_r == ID_EMERG && has_r) begin
        if (data_r == 8'd1) begin
          emerg_nxt        = 1'b1;
          target_nxt       = '0;
          relay_nxt        = 1'b0;
          zero_duty        = 1'b1;
          mid_nxt.fb_valid = 1'b1;
          mid_nxt.fb_id    = FB_SPEED;
          mid_nxt.two      = 1'b1;
        end else if (data_r == 8'd0) begin
          emerg_nxt = 1'b0;
        end
      end else if (!emerg_r && !off_nxt && has_r) begin
        if (id_r == ID_SPEED) begin
          target_nxt       = (data_r > {1'b0, SPEED_MAX}) ? SPEED_MAX : data_r[6:0];
          mid_nxt.fb_valid = 1'b1;
          mid_nxt.fb_id    = FB_SPEED;
          mid_nxt.fb_value = target_nxt;
        end else if (id_r == ID_RELAY) begin
          relay_nxt = dir_new;
          if (!dir_new) begin
            target_nxt = '0;
            zero_duty  = 1'b1;
          end
          mid_nxt.fb_valid = 1'b1;
          mid_nxt.fb_id    = FB_RELAY;
          mid_nxt.fb_value = {6'd0, dir_new};
        end else if (id_r == ID_DIR) begin
          if (dir_new != fwd_r) begin
            target_nxt = '0;
            zero_duty  = 1'b1;
            fwd_nxt    = dir_new;
          end
          mid_nxt.fb_valid = 1'b1;
          mid_nxt.fb_id    = FB_DIR;
          mid_nxt.fb_value = {6'd0, fwd_nxt};
        end
      end
    end

    if (!off_nxt && (elapsed_nxt > {1'b0, wd_timeout})) begin
      off_nxt    = 1'b1;
      target_nxt = '0;
      relay_nxt  = 1'b0;
      zero_duty  = 1'b1;
    end

    if (!emerg_nxt && !off_nxt) begin
      mid_nxt.duty_act = DUTY_CALC;
    end else if (zero_duty) begin
      mid_nxt.duty_act = DUTY_ZERO;
    end else begin
      mid_nxt.duty_act = DUTY_KEEP;
    end

    mid_nxt.prod      = PROD_W'(target_nxt) * PROD_W'(full_scale);
    mid_nxt.relay_on  = relay_nxt;
    mid_nxt.reverse   = !fwd_nxt;
    mid_nxt.emergency = emerg_nxt;
    mid_nxt.offline   = off_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      mid_v_r   <= 1'b0;
      target_r  <= '0;
      relay_r   <= 1'b0;
      fwd_r     <= 1'b1;
      emerg_r   <= 1'b0;
      off_r     <= 1'b1;
      elapsed_r <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        mid_v_r   <= 1'b1;
        target_r  <= target_nxt;
        relay_r   <= relay_nxt;
        fwd_r     <= fwd_nxt;
        emerg_r   <= emerg_nxt;
        off_r     <= off_nxt;
        elapsed_r <= elapsed_nxt;
      end else if (mid_ready) begin
        mid_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      id_r   <= in_frame_id;
      has_r  <= in_has_data;
      data_r <= in_data_byte;
    end
    if (s1_adv) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = mid_v_r;
  assign mid_rec   = mid_r;

endmodule

### rtl/mdcw_out.sv
// ----------------------------------------------------------------------------
// mdcw_out: duty scaling and result register
// Divides the registered product by one hundred, updates the duty and
// presents one or two result transactions per record.
// ----------------------------------------------------------------------------
module mdcw_out
  import mdcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        mid_valid,
  output logic        mid_ready,
  input  mid_rec_t    mid_rec,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_feedback_valid,
  output logic [10:0] out_feedback_id,
  output logic [6:0]  out_feedback_value,
  output logic [7:0]  out_pwm_duty,
  output logic        out_relay_on,
  output logic        out_reverse_pin,
  output logic        out_emergency_active,
  output logic        out_master_offline,
  output logic        out_last
);

  logic        out_v_r;
  logic        pend_r;
  logic        fbv_r;
  logic [10:0] fbid_r;
  logic [6:0]  fbval_r;
  logic        relay_r;
  logic        rev_r;
  logic        emerg_r;
  logic        off_r;
  logic        last_r;
  logic [7:0]  duty_r, duty_nxt;

  logic [SCALED_W-1:0] scaled;
  logic                out_fire;
  logic                load;

  assign scaled    = SCALED_W'(mid_rec.prod) * SCALED_W'(RECIP_100);
  assign out_fire  = out_v_r && !out_stall;
  assign mid_ready = !out_v_r || (out_fire && !pend_r);
  assign load      = mid_valid && mid_ready;

  always_comb begin
    unique case (mid_rec.duty_act)
      DUTY_CALC: duty_nxt = scaled[RECIP_SHIFT +: 8];
      DUTY_ZERO: duty_nxt = '0;
      default:   duty_nxt = duty_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      pend_r  <= 1'b0;
      duty_r  <= '0;
    end else begin
      if (load) begin
        out_v_r <= 1'b1;
        pend_r  <= mid_rec.two;
        duty_r  <= duty_nxt;
      end else if (out_fire && pend_r) begin
        pend_r <= 1'b0;
      end else if (out_fire) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fbv_r   <= mid_rec.fb_valid;
      fbid_r  <= mid_rec.fb_id;
      fbval_r <= mid_rec.fb_value;
      relay_r <= mid_rec.relay_on;
      rev_r   <= mid_rec.reverse;
      emerg_r <= mid_rec.emergency;
      off_r   <= mid_rec.offline;
      last_r  <= !mid_rec.two;
    end else if (out_fire && pend_r) begin
      fbid_r  <= FB_RELAY;
      fbval_r <= '0;
      last_r  <= 1'b1;
    end
  end

  assign out_valid            = out_v_r;
  assign out_feedback_valid   = fbv_r;
  assign out_feedback_id      = fbid_r;
  assign out_feedback_value   = fbval_r;
  assign out_pwm_duty         = duty_r;
  assign out_relay_on         = relay_r;
  assign out_reverse_pin      = rev_r;
  assign out_emergency_active = emerg_r;
  assign out_master_offline   = off_r;
  assign out_last             = last_r;

endmodule

### rtl/motor_drive_command_watchdog.sv
// ----------------------------------------------------------------------------
// motor_drive_command_watchdog: CAN motor command decoder with master watchdog
// Applies speed, relay, direction and emergency frames, counts millisecond
// ticks and drops to safe mode when the master goes silent.
// ----------------------------------------------------------------------------
// Each transaction is a received CAN frame or a one-millisecond tick. The block
// accepts one transaction per cycle while in_stall is low; a result passes
// through the input register, command stage and result register. An
// emergency-on frame yields two results and holds the result register until
// both are taken, so no new record enters it meanwhile. Every result carries
// the status after the whole transaction, watchdog check included.
// Registers: index 0 watchdog timeout in ms (reset 500), index 1 PWM full scale
// (reset 255); other indexes are ignored. Write them only while idle.
module motor_drive_command_watchdog
  import mdcw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [10:0]          in_frame_id,
  input  logic                 in_has_data,
  input  logic [7:0]           in_data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_feedback_valid,
  output logic [10:0]          out_feedback_id,
  output logic [6:0]           out_feedback_value,
  output logic [7:0]           out_pwm_duty,
  output logic                 out_relay_on,
  output logic                 out_reverse_pin,
  output logic                 out_emergency_active,
  output logic                 out_master_offline,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] wd_timeout_r;
  logic [7:0]  full_scale_r;
  logic        mid_valid;
  logic        mid_ready;
  mid_rec_t    mid_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_timeout_r <= WD_TIMEOUT_RST;
      full_scale_r <= FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WD_TIMEOUT) begin
        wd_timeout_r <= cfg_data;
      end else if (cfg_index == CFG_FULL_SCALE) begin
        full_scale_r <= cfg_data[7:0];
      end
    end
  end

  mdcw_cmd u_cmd (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_frame_id  (in_frame_id),
    .in_has_data  (in_has_data),
    .in_data_byte (in_data_byte),
    .wd_timeout   (wd_timeout_r),
    .full_scale   (full_scale_r),
    .mid_valid    (mid_valid),
    .mid_ready    (mid_ready),
    .mid_rec      (mid_rec)
  );

  mdcw_out u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .mid_valid            (mid_valid),
    .mid_ready            (mid_ready),
    .mid_rec              (mid_rec),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_feedback_valid   (out_feedback_valid),
    .out_feedback_id      (out_feedback_id),
    .out_feedback_value   (out_feedback_value),
    .out_pwm_duty         (out_pwm_duty),
    .out_relay_on         (out_relay_on),
    .out_reverse_pin      (out_reverse_pin),
    .out_emergency_active (out_emergency_active),
    .out_master_offline   (out_master_offline),
    .out_last             (out_last)
  );

endmodule
